// File: design/art_pkg.sv
// Shared types and codes for the acknowledgement retransmission table.
package art_pkg;

  localparam int ATT_BITS = 8;
  localparam int SLOT_PORT_BITS = 4;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_SCAN = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_RESEND  = 2'd1;
  localparam logic [1:0] KIND_ACKED   = 2'd2;
  localparam logic [1:0] KIND_GAVE_UP = 2'd3;

  localparam logic [1:0] REG_RETRY_LIMIT    = 2'd0;
  localparam logic [1:0] REG_RETRY_INTERVAL = 2'd1;

  localparam logic [ATT_BITS-1:0] ATT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic set_valid;
    logic clr_valid;
  } store_cmd_t;

endpackage

// File: design/ack_retransmit_table.sv
// Top level: acknowledgement retransmission table with send, ack and retry scan.
//
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// item in  | start, busy               | action, slot, now_time
// result   | strobe (one cycle)        | kind, slot_out, attempt_count, last_of_run
// config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// Send: busy stays low; result in the cycle after the accept edge, for an in-range slot.
// Ack: busy in ST_ACK (memory read); a result follows ST_ACK only if the slot was pending.
// Scan: busy until the run ends, one memory read per slot; each result trails its
//   slot by one word so the final one carries last_of_run, after busy falls.
// Reset clears all pending flags at once and loads retry_limit 5, retry_interval 500.
// cfg_ready is always high; results cannot be stalled.
module ack_retransmit_table
  import art_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                action,
  input  logic [SLOT_PORT_BITS-1:0] slot,
  input  logic [31:0]               now_time,
  output logic                      strobe,
  output logic [1:0]                kind,
  output logic [SLOT_PORT_BITS-1:0] slot_out,
  output logic [ATT_BITS-1:0]       attempt_count,
  output logic                      last_of_run,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data
);

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int PTR_BITS = $clog2(SLOTS + 1);

  state_t state, state_next;
  action_t act_in;
  logic accept;
  logic slot_ok;
  logic [SLOT_BITS-1:0] slot_idx;
  logic [SLOT_BITS-1:0] slot_q;
  logic [TIME_BITS-1:0] now_in;
  logic [TIME_BITS-1:0] now_q;
  logic [63:0] now_wide;
  logic [11:0] slot_wide;

  logic [ATT_BITS-1:0] retry_limit;
  logic [15:0] retry_interval;

  logic [PTR_BITS-1:0] rd_ptr;
  logic ev;
  logic [SLOT_BITS-1:0] ev_idx;
  logic scan_done;

  store_cmd_t cmd;
  logic [SLOT_BITS-1:0] rd_addr, wr_addr;
  logic [ATT_BITS-1:0] wr_att, rd_att;
  logic [TIME_BITS-1:0] wr_time, rd_time;
  logic [SLOTS-1:0] entry_valid;

  logic hit_valid, give_up, due, cand;
  logic [TIME_BITS-1:0] elapsed;
  logic [ATT_BITS-1:0] att_inc;
  logic [1:0] cand_kind;
  logic [ATT_BITS-1:0] cand_att;
  logic [SLOT_PORT_BITS-1:0] ev_slot;

  logic pend;
  logic [1:0] pend_kind;
  logic [SLOT_PORT_BITS-1:0] pend_slot;
  logic [ATT_BITS-1:0] pend_att;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign cfg_ready = 1'b1;
  assign act_in = action_t'(action);
  assign now_wide = {32'b0, now_time};
  assign now_in = now_wide[TIME_BITS-1:0];
  assign slot_wide = {8'b0, slot};
  assign slot_idx = slot_wide[SLOT_BITS-1:0];
  assign slot_ok = int'(slot) < SLOTS;
  assign scan_done = (rd_ptr == PTR_BITS'(SLOTS)) && !ev;
  assign ev_slot = SLOT_PORT_BITS'(ev_idx);

  art_store #(
    .SLOTS(SLOTS),
    .TIME_BITS(TIME_BITS)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_att(wr_att),
    .wr_time(wr_time),
    .rd_att(rd_att),
    .rd_time(rd_time),
    .entry_valid(entry_valid)
  );

  // scan evaluation of the entry read in the previous cycle
  always_comb begin
    hit_valid = ev && entry_valid[ev_idx];
    give_up = hit_valid && (retry_limit != '0) && (rd_att >= retry_limit);
    elapsed = now_q - rd_time;
    due = hit_valid && !give_up && (elapsed >= TIME_BITS'(retry_interval));
    att_inc = (rd_att == ATT_MAX) ? rd_att : rd_att + 1'b1;
    cand = give_up || due;
    cand_kind = give_up ? KIND_GAVE_UP : KIND_RESEND;
    cand_att = give_up ? rd_att : att_inc;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (act_in)
            ACT_ACK:  state_next = slot_ok ? ST_ACK : ST_IDLE;
            ACT_SCAN: state_next = ST_SCAN;
            ACT_SEND, ACT_NONE: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ACK:  state_next = ST_IDLE;
      ST_SCAN: state_next = scan_done ? ST_IDLE : ST_SCAN;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    rd_addr = slot_idx;
    wr_addr = slot_idx;
    wr_att = ATT_BITS'(1);
    wr_time = now_in;
    unique case (state)
      ST_IDLE: begin
        if (start && slot_ok) begin
          cmd.wr = (act_in == ACT_SEND);
          cmd.set_valid = (act_in == ACT_SEND);
          cmd.rd = (act_in == ACT_ACK);
        end
      end
      ST_ACK: begin
        wr_addr = slot_q;
        cmd.clr_valid = entry_valid[slot_q];
      end
      ST_SCAN: begin
        rd_addr = rd_ptr[SLOT_BITS-1:0];
        cmd.rd = (rd_ptr < PTR_BITS'(SLOTS));
        wr_addr = ev_idx;
        wr_att = att_inc;
        wr_time = now_q;
        cmd.wr = due;
        cmd.clr_valid = give_up;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      retry_limit <= 8'd5;
      retry_interval <= 16'd500;
      rd_ptr <= '0;
      ev <= 1'b0;
      pend <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == REG_RETRY_LIMIT) begin
          retry_limit <= cfg_data[ATT_BITS-1:0];
        end else if (cfg_index == REG_RETRY_INTERVAL) begin
          retry_interval <= cfg_data;
        end
      end
      unique case (state)
        ST_IDLE: begin
          rd_ptr <= '0;
          ev <= 1'b0;
          pend <= 1'b0;
          if (accept && act_in == ACT_SEND && slot_ok) begin
            strobe <= 1'b1;
          end
        end
        ST_ACK: begin
          strobe <= entry_valid[slot_q];
        end
        ST_SCAN: begin
          ev <= cmd.rd;
          if (cmd.rd) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (cand) begin
            pend <= 1'b1;
            strobe <= pend;
          end
          if (scan_done) begin
            pend <= 1'b0;
            strobe <= pend;
          end
        end
        default: pend <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_q <= slot_idx;
      now_q <= now_in;
    end
    if (state == ST_SCAN) begin
      ev_idx <= rd_addr;
      if (cand) begin
        pend_kind <= cand_kind;
        pend_slot <= ev_slot;
        pend_att <= cand_att;
      end
    end
    unique case (state)
      ST_IDLE: begin
        kind <= KIND_SEND;
        slot_out <= slot;
        attempt_count <= ATT_BITS'(1);
        last_of_run <= 1'b1;
      end
      ST_ACK: begin
        kind <= KIND_ACKED;
        slot_out <= SLOT_PORT_BITS'(slot_q);
        attempt_count <= rd_att;
        last_of_run <= 1'b1;
      end
      ST_SCAN: begin
        kind <= pend_kind;
        slot_out <= pend_slot;
        attempt_count <= pend_att;
        last_of_run <= scan_done;
      end
      default: last_of_run <= 1'b1;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    rd_ptr <= PTR_BITS'(SLOTS))
    else $error("scan pointer past last slot");

  a_ev_in_scan: assert property (@(posedge clk) disable iff (rst)
    ev |-> state == ST_SCAN)
    else $error("slot evaluation outside scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_done) |=> !busy)
    else $error("scan did not return to idle");

  a_send_result: assert property (@(posedge clk) disable iff (rst)
    (accept && act_in == ACT_SEND && slot_ok) |=> strobe && kind == KIND_SEND)
    else $error("send gave no first-transmit word");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !pend)
    else $error("held scan word left behind in idle");
`endif

endmodule

// File: design/art_store.sv
// Entry memory (attempts and send time) with per-slot pending flags.
module art_store
  import art_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int TIME_BITS = 32,
  localparam int SLOT_BITS = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  store_cmd_t           cmd,
  input  logic [SLOT_BITS-1:0] rd_addr,
  input  logic [SLOT_BITS-1:0] wr_addr,
  input  logic [ATT_BITS-1:0]  wr_att,
  input  logic [TIME_BITS-1:0] wr_time,
  output logic [ATT_BITS-1:0]  rd_att,
  output logic [TIME_BITS-1:0] rd_time,
  output logic [SLOTS-1:0]     entry_valid
);

  logic [ATT_BITS+TIME_BITS-1:0] mem [SLOTS];
  logic [ATT_BITS+TIME_BITS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= {wr_att, wr_time};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_att  = rd_data[ATT_BITS+TIME_BITS-1:TIME_BITS];
  assign rd_time = rd_data[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.set_valid) begin
      entry_valid[wr_addr] <= 1'b1;
    end else if (cmd.clr_valid) begin
      entry_valid[wr_addr] <= 1'b0;
    end
  end

endmodule
